// ===== design/dro_pkg.sv =====
// Shared types, constants and arithmetic helpers for the dead-reckoning
// odometry core: sine table, trig scaling, saturation and truncation.
// No dependencies.
package dro_pkg;

    // Angle constants in degrees
    localparam int DEG_FULL    = 360;
    localparam int DEG_HALF    = 180;
    localparam int DEG_QUARTER = 90;

    // Fixed-point and accumulator sizing
    localparam int TRIG_FRAC_BITS = 15;
    localparam int POSITION_WIDTH = 32;
    localparam int TRIG_MAG_W     = TRIG_FRAC_BITS + 1;
    localparam int TRIG_W         = TRIG_FRAC_BITS + 2;
    localparam int PROD_W         = 16 + TRIG_W;
    localparam int DELTA_W        = 17;
    localparam int WIDE_W         = 50;
    localparam int TOTAL_W        = 31;

    // Shift amounts that take the Q15 table to TRIG_FRAC_BITS
    localparam int TRIG_LSH  = (TRIG_FRAC_BITS >= 15) ? (TRIG_FRAC_BITS - 15) : 0;
    localparam int TRIG_RSH  = (TRIG_FRAC_BITS < 15) ? (15 - TRIG_FRAC_BITS) : 0;
    localparam int TRIG_HALF = (1 << TRIG_RSH) >> 1;
    localparam int TRIG_SCL_W = TRIG_MAG_W + 17;

    // Saturation limits of the position accumulators
    localparam logic signed [WIDE_W-1:0] POS_MAX =
        WIDE_W'((64'sd1 <<< (POSITION_WIDTH - 1)) - 64'sd1);
    localparam logic signed [WIDE_W-1:0] POS_MIN = -POS_MAX - WIDE_W'(1);

    localparam logic [TOTAL_W-1:0] TOTAL_MAX = {TOTAL_W{1'b1}};

    typedef logic [8:0] heading_t;
    typedef logic signed [POSITION_WIDTH-1:0] pos_t;
    typedef logic signed [TRIG_W-1:0] trig_t;
    typedef logic signed [DELTA_W-1:0] delta_t;
    typedef logic [TOTAL_W-1:0] total_t;

    // Q15 quarter-wave sine, 0..90 degrees, rounded to nearest
    localparam logic [15:0] SIN_Q15 [0:90] = '{
        16'd0,     16'd572,   16'd1144,  16'd1715,  16'd2286,  16'd2856,
        16'd3425,  16'd3993,  16'd4560,  16'd5126,  16'd5690,  16'd6252,
        16'd6813,  16'd7371,  16'd7927,  16'd8481,  16'd9032,  16'd9580,
        16'd10126, 16'd10668, 16'd11207, 16'd11743, 16'd12275, 16'd12803,
        16'd13328, 16'd13848, 16'd14365, 16'd14876, 16'd15384, 16'd15886,
        16'd16384, 16'd16877, 16'd17364, 16'd17847, 16'd18324, 16'd18795,
        16'd19261, 16'd19720, 16'd20174, 16'd20622, 16'd21063, 16'd21498,
        16'd21926, 16'd22348, 16'd22763, 16'd23170, 16'd23571, 16'd23965,
        16'd24351, 16'd24730, 16'd25102, 16'd25466, 16'd25822, 16'd26170,
        16'd26510, 16'd26842, 16'd27166, 16'd27482, 16'd27789, 16'd28088,
        16'd28378, 16'd28660, 16'd28932, 16'd29197, 16'd29452, 16'd29698,
        16'd29935, 16'd30163, 16'd30382, 16'd30592, 16'd30792, 16'd30983,
        16'd31164, 16'd31336, 16'd31499, 16'd31651, 16'd31795, 16'd31928,
        16'd32052, 16'd32166, 16'd32270, 16'd32365, 16'd32449, 16'd32524,
        16'd32588, 16'd32643, 16'd32688, 16'd32723, 16'd32748, 16'd32763,
        16'd32768
    };

    // Rescale a Q15 table entry to TRIG_FRAC_BITS, rounding half up
    function automatic logic [TRIG_MAG_W-1:0] trig_scale(input logic [15:0] q);
        logic [TRIG_SCL_W-1:0] w;
        if (TRIG_FRAC_BITS >= 15)
        begin
            w = TRIG_SCL_W'(q) << TRIG_LSH;
        end
        else
        begin
            w = (TRIG_SCL_W'(q) + TRIG_SCL_W'(TRIG_HALF)) >> TRIG_RSH;
        end
        return w[TRIG_MAG_W-1:0];
    endfunction

    // Signed sine of a heading in 0..359
    function automatic trig_t sin_deg(input heading_t h);
        heading_t a;
        logic     neg;
        trig_t    s;
        a   = h;
        neg = 1'b0;
        if (a >= heading_t'(DEG_HALF))
        begin
            a   = a - heading_t'(DEG_HALF);
            neg = 1'b1;
        end
        if (a > heading_t'(DEG_QUARTER))
        begin
            a = heading_t'(DEG_HALF) - a;
        end
        s = trig_t'({1'b0, trig_scale(SIN_Q15[a[6:0]])});
        return neg ? -s : s;
    endfunction

    // Cosine as the sine a quarter turn ahead
    function automatic trig_t cos_deg(input heading_t h);
        heading_t a;
        a = h + heading_t'(DEG_QUARTER);
        if (a >= heading_t'(DEG_FULL))
        begin
            a = a - heading_t'(DEG_FULL);
        end
        return sin_deg(a);
    endfunction

    // Clamp a wide signed value to the position range
    function automatic pos_t pos_sat(input logic signed [WIDE_W-1:0] v);
        logic signed [WIDE_W-1:0] c;
        if (v > POS_MAX)
        begin
            c = POS_MAX;
        end
        else if (v < POS_MIN)
        begin
            c = POS_MIN;
        end
        else
        begin
            c = v;
        end
        return c[POSITION_WIDTH-1:0];
    endfunction

    // Low 32 bits of a sign-extended position
    function automatic logic [31:0] pos_out(input pos_t p);
        logic signed [WIDE_W-1:0] w;
        w = WIDE_W'(p);
        return w[31:0];
    endfunction

    // Magnitude of a 16-bit signed step
    function automatic logic [15:0] abs16(input logic signed [15:0] v);
        logic signed [16:0] w;
        w = 17'(v);
        if (w < 0)
        begin
            w = -w;
        end
        return w[15:0];
    endfunction

    // Saturating add to a running total
    function automatic total_t total_add(input total_t acc, input logic [15:0] inc);
        logic [TOTAL_W:0] s;
        s = {1'b0, acc} + (TOTAL_W + 1)'(inc);
        return (s > (TOTAL_W + 1)'(TOTAL_MAX)) ? TOTAL_MAX : s[TOTAL_W-1:0];
    endfunction

    // Product divided by 2^TRIG_FRAC_BITS, truncated toward zero
    function automatic delta_t trunc_div(input logic signed [PROD_W-1:0] p);
        logic signed [PROD_W-1:0] adj;
        logic signed [PROD_W-1:0] q;
        adj = p;
        if (p[PROD_W-1])
        begin
            adj = p + PROD_W'((64'sd1 <<< TRIG_FRAC_BITS) - 64'sd1);
        end
        q = adj >>> TRIG_FRAC_BITS;
        return q[DELTA_W-1:0];
    endfunction

endpackage

// ===== design/dro_mod360.sv =====
// Reduces a signed 16-bit angle step to 0..359 degrees.
// Uses a reciprocal multiply with one correcting subtract; depends on dro_pkg.
module dro_mod360 (
    input  logic signed [15:0] angle,
    output dro_pkg::heading_t  angle_mod
);
    import dro_pkg::*;

    // 92 full turns lift every step into the positive range
    localparam int BIAS  = 92 * DEG_FULL;
    localparam int RECIP = (1 << 25) / DEG_FULL;

    logic signed [17:0] biased;
    logic [16:0]        u;
    logic [33:0]        prod;
    logic [8:0]         quot;
    logic [16:0]        quot_deg;
    logic [16:0]        rem;
    logic [9:0]         rem_lo;

    // Estimate the quotient; it can fall short by one
    always_comb
    begin
        biased   = 18'(angle) + 18'(BIAS);
        u        = biased[16:0];
        prod     = 34'(u) * 34'(RECIP);
        quot     = prod[33:25];
        quot_deg = 17'(quot) * 17'(DEG_FULL);
        rem      = u - quot_deg;
        rem_lo   = rem[9:0];
    end

    // Fold the remainder back once
    always_comb
    begin
        if (rem_lo >= 10'(DEG_FULL))
        begin
            angle_mod = heading_t'(rem_lo - 10'(DEG_FULL));
        end
        else
        begin
            angle_mod = heading_t'(rem_lo);
        end
    end

endmodule

// ===== design/dead_reckoning_odometry_core.sv =====
// Top level of the dead-reckoning odometry core: a six-register pipeline.
// Depends on dro_pkg and dro_mod360.

// The core takes one beat per clock while in_stall is low and returns one
// result beat per input beat, in order. Each beat goes through an input
// register, an angle reduction stage, the heading update, the sine and cosine
// lookup, the distance multiply, and the saturating accumulators that drive
// the outputs. The heading loop and the position loop each close inside a
// single stage, so a new beat can follow every cycle while the output does
// not stall; stages that are empty keep filling while a finished result
// waits on the output. A set-pose beat loads X, Y and heading and leaves the
// totals and the bumper and wall flags unchanged. Valid bits and odometry
// state clear on reset, the stage payload does not; there is no clearing pass.
module dead_reckoning_odometry_core (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic                 req_type,
    input  logic signed [15:0]   step_distance,
    input  logic signed [15:0]   step_angle,
    input  logic                 wall_seen,
    input  logic                 bump_left_raw,
    input  logic                 bump_right_raw,
    input  logic signed [31:0]   pose_x,
    input  logic signed [31:0]   pose_y,
    input  dro_pkg::heading_t    pose_heading,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic signed [31:0]   position_x,
    output logic signed [31:0]   position_y,
    output dro_pkg::heading_t    heading,
    output dro_pkg::total_t      distance_total,
    output dro_pkg::total_t      angle_total,
    output logic                 bump_front,
    output logic                 bump_left,
    output logic                 bump_right,
    output logic                 wall_flag
);
    import dro_pkg::*;

    typedef struct packed {
        logic               req;
        logic signed [15:0] distance;
        logic signed [15:0] angle;
        logic [15:0]        abs_dist;
        logic [15:0]        abs_angle;
        heading_t           angle_mod;
        logic               wall;
        logic               bl;
        logic               br;
        logic signed [31:0] px;
        logic signed [31:0] py;
        heading_t           hdg;
        trig_t              sin_v;
        trig_t              cos_v;
        delta_t             dx;
        delta_t             dy;
    } item_t;

    item_t s1_reg, s2_reg, s3_reg, s4_reg, s5_reg;
    item_t s1_next, s2_next, s3_next, s4_next, s5_next;
    logic  v1_reg, v2_reg, v3_reg, v4_reg, v5_reg, out_v_reg;
    logic  ld1, ld2, ld3, ld4, ld5, ld_out;

    heading_t hdg_state_reg, hdg_state_next;
    pos_t     pos_x_reg, pos_x_next;
    pos_t     pos_y_reg, pos_y_next;
    heading_t hdg_out_reg, hdg_out_next;
    total_t   dist_total_reg, dist_total_next;
    total_t   angle_total_reg, angle_total_next;
    logic     front_reg, front_next;
    logic     left_reg, left_next;
    logic     right_reg, right_next;
    logic     wall_reg, wall_next;

    heading_t                 angle_mod;
    logic [9:0]               hdg_wide;
    heading_t                 hdg_sum;
    logic signed [PROD_W-1:0] prod_x;
    logic signed [PROD_W-1:0] prod_y;

    // Advance each stage when the one after it is empty or moving
    always_comb
    begin
        ld_out   = v5_reg && (!out_v_reg || !out_stall);
        ld5      = v4_reg && (!v5_reg || ld_out);
        ld4      = v3_reg && (!v4_reg || ld5);
        ld3      = v2_reg && (!v3_reg || ld4);
        ld2      = v1_reg && (!v2_reg || ld3);
        in_stall = v1_reg && !ld2;
        ld1      = in_valid && !in_stall;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg    <= 1'b0;
            v2_reg    <= 1'b0;
            v3_reg    <= 1'b0;
            v4_reg    <= 1'b0;
            v5_reg    <= 1'b0;
            out_v_reg <= 1'b0;
        end
        else
        begin
            v1_reg    <= ld1 || (v1_reg && !ld2);
            v2_reg    <= ld2 || (v2_reg && !ld3);
            v3_reg    <= ld3 || (v3_reg && !ld4);
            v4_reg    <= ld4 || (v4_reg && !ld5);
            v5_reg    <= ld5 || (v5_reg && !ld_out);
            out_v_reg <= ld_out || (out_v_reg && out_stall);
        end
    end

    // Capture the input beat
    always_comb
    begin
        s1_next           = '0;
        s1_next.req       = req_type;
        s1_next.distance  = step_distance;
        s1_next.angle     = step_angle;
        s1_next.wall      = wall_seen;
        s1_next.bl        = bump_left_raw;
        s1_next.br        = bump_right_raw;
        s1_next.px        = pose_x;
        s1_next.py        = pose_y;
        s1_next.hdg       = pose_heading;
    end

    // Reduce the angle step and take magnitudes
    dro_mod360 u_mod360 (
        .angle     (s1_reg.angle),
        .angle_mod (angle_mod)
    );

    always_comb
    begin
        s2_next           = s1_reg;
        s2_next.angle_mod = angle_mod;
        s2_next.abs_dist  = abs16(s1_reg.distance);
        s2_next.abs_angle = abs16(s1_reg.angle);
        if (s1_reg.hdg >= heading_t'(DEG_FULL))
        begin
            s2_next.hdg = s1_reg.hdg - heading_t'(DEG_FULL);
        end
    end

    // Update the heading; a set-pose beat loads it
    always_comb
    begin
        hdg_wide = 10'(hdg_state_reg) + 10'(s2_reg.angle_mod);
        if (hdg_wide >= 10'(DEG_FULL))
        begin
            hdg_wide = hdg_wide - 10'(DEG_FULL);
        end
        hdg_sum        = hdg_wide[8:0];
        hdg_state_next = s2_reg.req ? s2_reg.hdg : hdg_sum;
        s3_next        = s2_reg;
        s3_next.hdg    = hdg_state_next;
    end

    // Look up sine and cosine of the new heading
    always_comb
    begin
        s4_next       = s3_reg;
        s4_next.sin_v = sin_deg(s3_reg.hdg);
        s4_next.cos_v = cos_deg(s3_reg.hdg);
    end

    // Scale the step by the trig values
    always_comb
    begin
        prod_x     = PROD_W'(s4_reg.distance) * PROD_W'(s4_reg.sin_v);
        prod_y     = PROD_W'(s4_reg.distance) * PROD_W'(s4_reg.cos_v);
        s5_next    = s4_reg;
        s5_next.dx = trunc_div(prod_x);
        s5_next.dy = trunc_div(prod_y);
    end

    // Accumulate position and totals, decode the bumpers
    always_comb
    begin
        hdg_out_next     = s5_reg.hdg;
        pos_x_next       = pos_sat(WIDE_W'(pos_x_reg) - WIDE_W'(s5_reg.dx));
        pos_y_next       = pos_sat(WIDE_W'(pos_y_reg) + WIDE_W'(s5_reg.dy));
        dist_total_next  = total_add(dist_total_reg, s5_reg.abs_dist);
        angle_total_next = total_add(angle_total_reg, s5_reg.abs_angle);
        front_next       = s5_reg.bl && s5_reg.br;
        left_next        = s5_reg.bl && !s5_reg.br;
        right_next       = s5_reg.br && !s5_reg.bl;
        wall_next        = s5_reg.wall;
        if (s5_reg.req)
        begin
            pos_x_next       = pos_sat(WIDE_W'(s5_reg.px));
            pos_y_next       = pos_sat(WIDE_W'(s5_reg.py));
            dist_total_next  = dist_total_reg;
            angle_total_next = angle_total_reg;
            front_next       = front_reg;
            left_next        = left_reg;
            right_next       = right_reg;
            wall_next        = wall_reg;
        end
    end

    // Pipeline payload: no reset
    always_ff @(posedge clk)
    begin
        if (ld1)
        begin
            s1_reg <= s1_next;
        end
        if (ld2)
        begin
            s2_reg <= s2_next;
        end
        if (ld3)
        begin
            s3_reg <= s3_next;
        end
        if (ld4)
        begin
            s4_reg <= s4_next;
        end
        if (ld5)
        begin
            s5_reg <= s5_next;
        end
    end

    // Odometry state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hdg_state_reg   <= '0;
            pos_x_reg       <= '0;
            pos_y_reg       <= '0;
            hdg_out_reg     <= '0;
            dist_total_reg  <= '0;
            angle_total_reg <= '0;
            front_reg       <= 1'b0;
            left_reg        <= 1'b0;
            right_reg       <= 1'b0;
            wall_reg        <= 1'b0;
        end
        else
        begin
            if (ld3)
            begin
                hdg_state_reg <= hdg_state_next;
            end
            if (ld_out)
            begin
                pos_x_reg       <= pos_x_next;
                pos_y_reg       <= pos_y_next;
                hdg_out_reg     <= hdg_out_next;
                dist_total_reg  <= dist_total_next;
                angle_total_reg <= angle_total_next;
                front_reg       <= front_next;
                left_reg        <= left_next;
                right_reg       <= right_next;
                wall_reg        <= wall_next;
            end
        end
    end

    // Drive the result ports
    assign out_valid      = out_v_reg;
    assign position_x     = pos_out(pos_x_reg);
    assign position_y     = pos_out(pos_y_reg);
    assign heading        = hdg_out_reg;
    assign distance_total = dist_total_reg;
    assign angle_total    = angle_total_reg;
    assign bump_front     = front_reg;
    assign bump_left      = left_reg;
    assign bump_right     = right_reg;
    assign wall_flag      = wall_reg;

`ifndef SYNTHESIS
    // The heading loop stays inside one turn
    assert property (@(posedge clk) disable iff (!rst_n)
        hdg_out_reg < heading_t'(DEG_FULL) && hdg_state_reg < heading_t'(DEG_FULL))
    else $error("heading left the 0..359 range");

    // A heading update reaches stage three together with the state
    assert property (@(posedge clk) disable iff (!rst_n)
        ld3 |=> s3_reg.hdg == hdg_state_reg)
    else $error("stage three heading differs from heading state");

    // Running totals never decrease
    assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |=> dist_total_reg >= $past(dist_total_reg)
            && angle_total_reg >= $past(angle_total_reg))
    else $error("running total decreased");

    // Input stalls only when the first stage is held full
    assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> v1_reg && v2_reg && v3_reg && v4_reg && v5_reg && out_v_reg)
    else $error("input stalled with room in the pipeline");
`endif

endmodule
